/* sv/ptdt_pkg.sv */
package ptdt_pkg;

  localparam int MaxTasks = 16;
  localparam int IdxW     = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW     = $clog2(MaxTasks + 1);
  localparam int IdW      = 4;
  localparam int OpW      = 3;
  localparam int KindW    = 2;
  localparam int WordW    = 32;

  localparam int InDataW  = 136;
  localparam int OutDataW = 72;

  localparam logic [OpW-1:0] OP_CREATE  = 3'd0;
  localparam logic [OpW-1:0] OP_DELETE  = 3'd1;
  localparam logic [OpW-1:0] OP_SUSPEND = 3'd2;
  localparam logic [OpW-1:0] OP_WAKE    = 3'd3;
  localparam logic [OpW-1:0] OP_TICK    = 3'd4;

  localparam logic [KindW-1:0] KIND_REPLY    = 2'd0;
  localparam logic [KindW-1:0] KIND_DISPATCH = 2'd1;
  localparam logic [KindW-1:0] KIND_END      = 2'd2;

  typedef enum logic [1:0] {
    WR_CREATE,
    WR_MOVE,
    WR_PAUSE,
    WR_BEAT
  } wr_sel_e;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_TASK,
    ID_COUNT,
    ID_ENTRY
  } id_sel_e;

  typedef struct packed {
    logic [IdW-1:0]   ident;
    logic [WordW-1:0] period;
    logic [WordW-1:0] last_beat;
    logic             paused;
    logic [WordW-1:0] handle;
    logic [WordW-1:0] user;
  } entry_t;

  typedef struct packed {
    logic             in_ready;
    logic             in_load;
    logic [IdxW-1:0]  rd_addr;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    wr_sel_e          wr_sel;
    logic             cnt_inc;
    logic             cnt_dec;
    logic             out_load;
    logic [KindW-1:0] out_kind;
    logic             out_ok;
    id_sel_e          out_id_sel;
    logic             out_last;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0]  op;
    logic            handle_zero;
    logic [CntW-1:0] count;
    logic            id_match;
    logic            due;
    logic            out_free;
  } status_t;

endpackage

/* sv/periodic_task_dispatch_table.sv */
// Periodic task dispatch table.
// The slave stream carries one request per transfer: the operation code in
// tuser (create, delete, suspend, wake up or tick scan) and its arguments in
// tdata. The master stream returns results: a reply for each table
// operation, and for a tick scan one dispatch per due task followed by an
// end-of-scan marker. tlast marks the final result of each request.
// The block works on one request at a time. A create registers its reply in
// the decode state once the output register is free; an unused operation
// code, or any other request on an empty table, goes from the decode state
// to a reply or end state that registers its result. Delete, suspend and
// wake up walk the table one entry per cycle through the entry memory's
// single read port; a delete that finds its task then copies the last entry
// into its slot in a move state before the reply. A tick scan reads one
// entry per cycle while no due entry waits on a stalled receiver, and
// registers its end marker from the finish state. A new request can be taken
// in the cycle after the final result is registered.
// When the receiver stalls, the output register holds its result and the
// scan waits on the entry that is due until that result has been taken.
// Reset empties the table at once by clearing the entry count; the entry
// memory itself is not cleared.
module periodic_task_dispatch_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // task_id[3:0], period[35:4], handle[67:36], user_word[99:68],
  // beat[131:100], zero fill
  input  logic [ptdt_pkg::InDataW-1:0]        s_axis_tdata,
  // op[2:0]
  input  logic [ptdt_pkg::OpW-1:0]            s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // ok[0], result_id[4:1], out_handle[36:5], out_user_word[68:37], zero fill
  output logic [ptdt_pkg::OutDataW-1:0]       m_axis_tdata,
  // kind[1:0]
  output logic [ptdt_pkg::KindW-1:0]          m_axis_tuser,
  output logic                                m_axis_tlast
);
  import ptdt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ptdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ptdt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;

endmodule

/* sv/ptdt_datapath.sv */
module ptdt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ptdt_pkg::cmd_t                   cmd_i,
  output ptdt_pkg::status_t                status_o,
  input  logic [ptdt_pkg::InDataW-1:0]     in_data_i,
  input  logic [ptdt_pkg::OpW-1:0]         in_op_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ptdt_pkg::OutDataW-1:0]    out_data_o,
  output logic [ptdt_pkg::KindW-1:0]       out_kind_o,
  output logic                             out_last_o
);
  import ptdt_pkg::*;

  logic [OpW-1:0]   op_q;
  logic [IdW-1:0]   task_id_q;
  logic [WordW-1:0] period_q;
  logic [WordW-1:0] handle_q;
  logic [WordW-1:0] user_q;
  logic [WordW-1:0] beat_q;

  logic [CntW-1:0]  count_q, count_d;

  entry_t           mem_q [MaxTasks];
  entry_t           rdata_q;
  entry_t           wr_data;

  logic             out_valid_q, out_valid_d;
  logic [KindW-1:0] out_kind_q;
  logic             out_ok_q;
  logic [IdW-1:0]   out_id_q;
  logic [WordW-1:0] out_handle_q;
  logic [WordW-1:0] out_user_q;
  logic             out_last_q;
  logic [IdW-1:0]   id_sel;
  logic [WordW-1:0] elapsed;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      op_q      <= in_op_i;
      task_id_q <= in_data_i[3:0];
      period_q  <= in_data_i[35:4];
      handle_q  <= in_data_i[67:36];
      user_q    <= in_data_i[99:68];
      beat_q    <= in_data_i[131:100];
    end
  end

  always_comb begin
    wr_data = rdata_q;
    case (cmd_i.wr_sel)
      WR_CREATE: begin
        wr_data.ident     = IdW'(count_q);
        wr_data.period    = period_q;
        wr_data.last_beat = '0;
        wr_data.paused    = 1'b0;
        wr_data.handle    = handle_q;
        wr_data.user      = user_q;
      end
      WR_PAUSE: wr_data.paused    = (op_q == OP_SUSPEND);
      WR_BEAT:  wr_data.last_beat = beat_q;
      default:  wr_data = rdata_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[cmd_i.rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign elapsed = beat_q - rdata_q.last_beat;

  always_comb begin
    status_o.op          = op_q;
    status_o.handle_zero = (handle_q == '0);
    status_o.count       = count_q;
    status_o.id_match    = (rdata_q.ident == task_id_q);
    status_o.due         = !rdata_q.paused && (elapsed >= rdata_q.period) &&
                           (rdata_q.handle != '0);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

  always_comb begin
    case (cmd_i.out_id_sel)
      ID_TASK:  id_sel = task_id_q;
      ID_COUNT: id_sel = IdW'(count_q);
      ID_ENTRY: id_sel = rdata_q.ident;
      default:  id_sel = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      out_ok_q   <= cmd_i.out_ok;
      out_id_q   <= id_sel;
      out_last_q <= cmd_i.out_last;
      if (cmd_i.out_kind == KIND_DISPATCH) begin
        out_handle_q <= rdata_q.handle;
        out_user_q   <= rdata_q.user;
      end else begin
        out_handle_q <= '0;
        out_user_q   <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {3'b000, out_user_q, out_handle_q, out_id_q, out_ok_q};

endmodule

/* sv/ptdt_ctrl.sv */
module ptdt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ptdt_pkg::status_t status_i,
  output ptdt_pkg::cmd_t    cmd_o
);
  import ptdt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_MOVE   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_REPLY  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            ok_q, ok_d;
  logic            last_idx;
  logic            full;
  logic [CntW-1:0] top_cnt;

  assign last_idx = ((CntW'(idx_q) + CntW'(1)) == status_i.count);
  assign full     = (status_i.count >= CntW'(MaxTasks));
  assign top_cnt  = status_i.count - CntW'(1);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ok_d    = ok_q;

    cmd_o            = '0;
    cmd_o.wr_sel     = WR_MOVE;
    cmd_o.out_id_sel = ID_ZERO;
    cmd_o.out_kind   = KIND_REPLY;
    cmd_o.wr_addr    = idx_q;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.in_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status_i.op) inside
          OP_CREATE: begin
            if (status_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (!status_i.handle_zero && !full) begin
                cmd_o.wr_en      = 1'b1;
                cmd_o.wr_addr    = status_i.count[IdxW-1:0];
                cmd_o.wr_sel     = WR_CREATE;
                cmd_o.cnt_inc    = 1'b1;
                cmd_o.out_ok     = 1'b1;
                cmd_o.out_id_sel = ID_COUNT;
              end
              state_d = S_IDLE;
            end
          end
          OP_DELETE, OP_SUSPEND, OP_WAKE: begin
            idx_d = '0;
            if (status_i.count == '0) begin
              ok_d    = 1'b0;
              state_d = S_REPLY;
            end else begin
              state_d = S_SEARCH;
            end
          end
          OP_TICK: begin
            idx_d = '0;
            if (status_i.count == '0) begin
              state_d = S_FINISH;
            end else begin
              state_d = S_SCAN;
            end
          end
          default: begin
            ok_d    = 1'b0;
            state_d = S_REPLY;
          end
        endcase
      end
      S_SEARCH: begin
        if (status_i.id_match) begin
          if (status_i.op == OP_DELETE) begin
            state_d = S_MOVE;
          end else begin
            cmd_o.wr_en  = 1'b1;
            cmd_o.wr_sel = WR_PAUSE;
            ok_d         = 1'b1;
            state_d      = S_REPLY;
          end
        end else if (last_idx) begin
          ok_d    = 1'b0;
          state_d = S_REPLY;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      S_MOVE: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_MOVE;
        cmd_o.cnt_dec = 1'b1;
        ok_d          = 1'b1;
        state_d       = S_REPLY;
      end
      S_SCAN: begin
        if (!status_i.due || status_i.out_free) begin
          if (status_i.due) begin
            cmd_o.out_load   = 1'b1;
            cmd_o.out_kind   = KIND_DISPATCH;
            cmd_o.out_ok     = 1'b1;
            cmd_o.out_id_sel = ID_ENTRY;
            cmd_o.wr_en      = 1'b1;
            cmd_o.wr_sel     = WR_BEAT;
          end
          if (last_idx) begin
            state_d = S_FINISH;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      S_REPLY: begin
        if (status_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_ok     = ok_q;
          cmd_o.out_id_sel = ok_q ? ID_TASK : ID_ZERO;
          cmd_o.out_last   = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = KIND_END;
          cmd_o.out_ok   = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    cmd_o.rd_addr = idx_d;
    if (state_q == S_SEARCH && status_i.id_match && status_i.op == OP_DELETE) begin
      cmd_o.rd_addr = top_cnt[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
    end
  end

endmodule

/* dv/tb_periodic_task_dispatch_table.sv */
module tb_periodic_task_dispatch_table;
  import ptdt_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ReportLimit = 10;
  localparam logic [OpW-1:0] OP_RESERVED_LO = OP_TICK + 3'd1;
  localparam logic [OpW-1:0] OP_RESERVED_HI = '1;

  typedef struct {
    logic [KindW-1:0] kind;
    logic             ok;
    logic [IdW-1:0]   id;
    logic [WordW-1:0] handle;
    logic [WordW-1:0] user;
    logic             last;
  } result_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_ONE_IN_FOUR,
    RDY_SPARSE
  } rdy_style_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [OpW-1:0]      s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  logic [IdW-1:0]   task_ident [MaxTasks];
  logic [WordW-1:0] task_period [MaxTasks];
  logic [WordW-1:0] task_last_beat [MaxTasks];
  logic             task_paused [MaxTasks];
  logic [WordW-1:0] task_handle [MaxTasks];
  logic [WordW-1:0] task_user [MaxTasks];
  int               task_count = 0;

  result_t          expected_results [$];
  int               mismatch_count = 0;
  int               cycle_count = 0;
  logic [WordW-1:0] beat_now = '0;
  int               stall_phase = 0;
  rdy_style_e       stall_style = RDY_ALWAYS;

  periodic_task_dispatch_table u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The receiver changes its stall style every so often, including long
  // stretches in which it never stalls.
  always @(posedge clk_i) begin
    if (stall_phase == 0) begin
      stall_phase <= $urandom_range(1, 200);
      stall_style <= rdy_style_e'($urandom_range(0, 3));
    end else begin
      stall_phase <= stall_phase - 1;
    end
    case (stall_style)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_COIN: m_axis_tready <= ($urandom_range(0, 1) == 1);
      RDY_ONE_IN_FOUR: m_axis_tready <= (stall_phase % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void push_result(logic [KindW-1:0] kind, logic ok, logic [IdW-1:0] id,
                                      logic [WordW-1:0] handle, logic [WordW-1:0] user,
                                      logic last);
    result_t r;
    r.kind = kind;
    r.ok = ok;
    r.id = id;
    r.handle = handle;
    r.user = user;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  function automatic int lookup_task(logic [IdW-1:0] id);
    for (int i = 0; i < task_count; i++) begin
      if (task_ident[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void clear_table();
    task_count = 0;
    for (int i = 0; i < MaxTasks; i++) begin
      task_ident[i] = '0;
      task_period[i] = '0;
      task_last_beat[i] = '0;
      task_paused[i] = 1'b0;
      task_handle[i] = '0;
      task_user[i] = '0;
    end
  endfunction

  // Applies one request to the table and queues the results it causes.
  function automatic void predict_request(logic [OpW-1:0] op, logic [IdW-1:0] id,
                                          logic [WordW-1:0] period,
                                          logic [WordW-1:0] handle,
                                          logic [WordW-1:0] user, logic [WordW-1:0] beat);
    int slot;
    int top;
    case (op)
      OP_CREATE: begin
        if (handle == '0 || task_count >= MaxTasks) begin
          push_result(KIND_REPLY, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          slot = task_count;
          task_ident[slot] = slot[IdW-1:0];
          task_period[slot] = period;
          task_last_beat[slot] = '0;
          task_paused[slot] = 1'b0;
          task_handle[slot] = handle;
          task_user[slot] = user;
          task_count++;
          push_result(KIND_REPLY, 1'b1, slot[IdW-1:0], '0, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        slot = lookup_task(id);
        if (slot < 0) begin
          push_result(KIND_REPLY, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          top = task_count - 1;
          task_ident[slot] = task_ident[top];
          task_period[slot] = task_period[top];
          task_last_beat[slot] = task_last_beat[top];
          task_paused[slot] = task_paused[top];
          task_handle[slot] = task_handle[top];
          task_user[slot] = task_user[top];
          task_ident[top] = '0;
          task_period[top] = '0;
          task_last_beat[top] = '0;
          task_paused[top] = 1'b0;
          task_handle[top] = '0;
          task_user[top] = '0;
          task_count = top;
          push_result(KIND_REPLY, 1'b1, id, '0, '0, 1'b1);
        end
      end
      OP_SUSPEND, OP_WAKE: begin
        slot = lookup_task(id);
        if (slot < 0) begin
          push_result(KIND_REPLY, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          task_paused[slot] = (op == OP_SUSPEND);
          push_result(KIND_REPLY, 1'b1, id, '0, '0, 1'b1);
        end
      end
      OP_TICK: begin
        for (int i = 0; i < task_count; i++) begin
          if (!task_paused[i] && (beat - task_last_beat[i]) >= task_period[i] &&
              task_handle[i] != '0) begin
            task_last_beat[i] = beat;
            push_result(KIND_DISPATCH, 1'b1, task_ident[i], task_handle[i], task_user[i],
                        1'b0);
          end
        end
        push_result(KIND_END, 1'b1, '0, '0, '0, 1'b1);
      end
      default: push_result(KIND_REPLY, 1'b0, '0, '0, '0, 1'b1);
    endcase
  endfunction

  task automatic send_request(input logic [OpW-1:0] op, input logic [IdW-1:0] id,
                              input logic [WordW-1:0] period, input logic [WordW-1:0] handle,
                              input logic [WordW-1:0] user, input logic [WordW-1:0] beat);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {{(InDataW - 4 * WordW - IdW){1'b0}}, beat, user, handle, period, id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(op, id, period, handle, user, beat);
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    result_t seen;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind = m_axis_tuser;
      seen.ok = m_axis_tdata[0];
      seen.id = m_axis_tdata[4:1];
      seen.handle = m_axis_tdata[36:5];
      seen.user = m_axis_tdata[68:37];
      seen.last = m_axis_tlast;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected transfer: kind %0d ok %0d id %0d handle %h user %h last %0d",
                   seen.kind, seen.ok, seen.id, seen.handle, seen.user, seen.last);
        end
      end else begin
        want = expected_results.pop_front();
        if (seen.kind !== want.kind || seen.ok !== want.ok || seen.id !== want.id ||
            seen.handle !== want.handle || seen.user !== want.user ||
            seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("mismatch: expected kind %0d ok %0d id %0d handle %h user %h last %0d",
                     want.kind, want.ok, want.id, want.handle, want.user, want.last);
            $display("          actual   kind %0d ok %0d id %0d handle %h user %h last %0d",
                     seen.kind, seen.ok, seen.id, seen.handle, seen.user, seen.last);
          end
        end
      end
    end
  end

  // Requests on an empty table: a create without a handle, a wake up of an
  // absent task, a reserved operation and a scan with nothing in it.
  task automatic test_empty_table();
    send_request(OP_CREATE, '1, '1, '0, '1, '1);
    send_request(OP_WAKE, '0, $urandom, $urandom, $urandom, $urandom);
    send_request(OP_RESERVED_LO, IdW'($urandom), $urandom, $urandom, $urandom, $urandom);
    send_request(OP_TICK, '0, '0, '0, '0, '0);
  endtask

  // Fills the table with extreme periods, handles and user words, then
  // tries one create too many.
  task automatic test_fill_table();
    logic [WordW-1:0] period;
    logic [WordW-1:0] handle;
    logic [WordW-1:0] user;
    for (int i = 0; i < MaxTasks; i++) begin
      period = (i == 0) ? '0 : (i == 1) ? '1 : WordW'(i);
      handle = (i == 2) ? '1 : WordW'(i + 1);
      user = (i == 3) ? '1 : (i == 4) ? '0 : $urandom;
      send_request(OP_CREATE, IdW'($urandom), period, handle, user, $urandom);
    end
    send_request(OP_CREATE, '0, '0, $urandom | 32'h1, $urandom, $urandom);
  endtask

  // Scans at beat zero, the top beat and across the wrap, with one task
  // suspended.
  task automatic test_scan_and_pause();
    send_request(OP_TICK, IdW'($urandom), $urandom, $urandom, $urandom, '0);
    send_request(OP_SUSPEND, 4'd3, $urandom, $urandom, $urandom, $urandom);
    send_request(OP_TICK, IdW'($urandom), $urandom, $urandom, $urandom, '1);
    send_request(OP_TICK, IdW'($urandom), $urandom, $urandom, $urandom, 32'd5);
    beat_now = 32'd5;
  endtask

  // Deleting from the middle moves the last entry down; the next create
  // then reuses an id that is still present, and the first match wins.
  task automatic test_delete_and_reuse();
    send_request(OP_DELETE, 4'd5, $urandom, $urandom, $urandom, $urandom);
    send_request(OP_CREATE, IdW'($urandom), 32'd2, $urandom | 32'h1, $urandom, $urandom);
    send_request(OP_SUSPEND, 4'd15, $urandom, $urandom, $urandom, $urandom);
    send_request(OP_DELETE, 4'd15, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int burst_left;
    logic [OpW-1:0] op;
    logic [IdW-1:0] id;
    logic [WordW-1:0] period;
    logic [WordW-1:0] handle;
    logic [WordW-1:0] beat;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 99) begin
        drain_results();
      end
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 20) op = OP_CREATE;
      else if (pick < 34) op = OP_DELETE;
      else if (pick < 42) op = OP_SUSPEND;
      else if (pick < 50) op = OP_WAKE;
      else if (pick < 94) op = OP_TICK;
      else op = OpW'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      if (task_count > 0 && $urandom_range(0, 9) != 0) begin
        id = task_ident[$urandom_range(0, task_count - 1)];
      end else begin
        id = IdW'($urandom);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) period = $urandom_range(0, 8);
      else if (pick < 9) period = $urandom_range(0, 64);
      else period = $urandom;
      handle = $urandom;
      if ($urandom_range(0, 19) == 0) handle = '0;
      else if (handle == '0) handle = 32'h1;
      if (op == OP_TICK) begin
        if ($urandom_range(0, 19) == 0) beat_now = $urandom;
        else beat_now = beat_now + $urandom_range(0, 12);
        beat = beat_now;
      end else begin
        beat = $urandom;
      end
      send_request(op, id, period, handle, $urandom, beat);
    end
  endtask

  initial begin
    clear_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_table();
    test_scan_and_pause();
    test_delete_and_reuse();
    drain_results();
    test_random_traffic(400);
    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ptdt_pkg.sv
sv/ptdt_datapath.sv
sv/ptdt_ctrl.sv
sv/periodic_task_dispatch_table.sv
dv/tb_periodic_task_dispatch_table.sv
